>>> hw/rtl/cang_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cang_pkg
// Shared types and constants for the cellular automaton next-generation block.
// ----------------------------------------------------------------------------
package cang_pkg;

    // Default neighbourhood limit; the top level hands it down as a parameter.
    localparam int MAX_NEIGHBOURS_DEF = 5;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_WORD    = 1'b1;

    localparam int CFG_DATA_W = 32;
    localparam int PCOUNT_W   = 3;
    localparam int RULE_W     = 32;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_RULE = 2'd1,
        ST_EVEN_LEN = 2'd2
    } t_status;

    // One result beat, as passed from the core to the output buffer.
    typedef struct packed {
        logic    cell_bit;
        logic    last;
        t_status status;
    } t_result;

endpackage : cang_pkg
`default_nettype wire

>>> hw/rtl/cang_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cang_core
// Configuration registers, neighbourhood window, rule lookup and flush counter.
// ----------------------------------------------------------------------------
module cang_core #(
    parameter int MAX_NEIGHBOURS = cang_pkg::MAX_NEIGHBOURS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [cang_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cang_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_mode,
    input  wire logic                            i_cell,
    input  wire logic                            i_last,
    input  wire logic                            i_buf_full,
    output logic                                 o_in_ready,
    output logic                                 o_push,
    output cang_pkg::t_result                    o_result
);
    import cang_pkg::*;

    localparam int WIN_W  = (MAX_NEIGHBOURS > 1) ? MAX_NEIGHBOURS - 1 : 1;
    localparam int FULL_W = WIN_W + 1;
    localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1);

    logic [PCOUNT_W-1:0] r_pc;
    logic [RULE_W-1:0]   r_rule;
    logic [WIN_W-1:0]    r_window, n_window;
    logic                r_bg, n_bg;
    logic                r_odd, n_odd;
    logic                r_in_gen, n_in_gen;
    logic [CNT_W-1:0]    r_flush_left, n_flush_left;

    logic              rule_ok;
    logic              flushing;
    logic              accept;
    logic [WIN_W-1:0]  base_win;
    logic              shift_bit;
    logic [FULL_W-1:0] full;
    logic [FULL_W-1:0] idx_mask;
    logic [FULL_W-1:0] idx;
    logic [RULE_W-1:0] cell_sh;
    logic              new_cell;
    logic [7:0]        top_idx;
    logic [RULE_W-1:0] top_sh;
    logic              bg_update;
    logic              odd_new;

    // The rule word must have no bits at or above 2^parent_count.
    always_comb begin
        rule_ok = 1'b0;
        if (r_pc != '0 && 32'(r_pc) <= 32'(MAX_NEIGHBOURS)) begin
            unique case (r_pc)
                3'd1:    rule_ok = (r_rule[31:2] == '0);
                3'd2:    rule_ok = (r_rule[31:4] == '0);
                3'd3:    rule_ok = (r_rule[31:8] == '0);
                3'd4:    rule_ok = (r_rule[31:16] == '0);
                default: rule_ok = 1'b1;
            endcase
        end
    end

    always_comb begin
        for (int b = 0; b < FULL_W; b++) begin
            idx_mask[b] = (int'(r_pc) > b);
        end
    end

    assign flushing   = (r_flush_left != '0);
    assign o_in_ready = !flushing && !i_buf_full;
    assign accept     = i_in_valid && o_in_ready;

    // One shared shift-and-lookup serves both cell beats and flush beats.
    always_comb begin
        base_win  = r_window;
        shift_bit = r_bg;
        if (!flushing) begin
            if (!r_in_gen) begin
                base_win = r_bg ? '1 : '0;
            end
            shift_bit = i_cell;
        end
    end

    assign full     = {base_win, shift_bit};
    assign idx      = full & idx_mask;
    assign cell_sh  = r_rule >> idx;
    assign new_cell = cell_sh[0];

    // Background follows the rule for an all-ones or all-zeros neighbourhood.
    assign top_idx   = (8'd1 << r_pc) - 8'd1;
    assign top_sh    = r_rule >> top_idx;
    assign bg_update = r_bg ? top_sh[0] : r_rule[0];

    assign odd_new = ~(r_in_gen ? r_odd : 1'b0);

    always_comb begin
        n_window     = r_window;
        n_bg         = r_bg;
        n_odd        = r_odd;
        n_in_gen     = r_in_gen;
        n_flush_left = r_flush_left;
        o_push       = 1'b0;
        o_result     = '{cell_bit: 1'b0, last: 1'b0, status: ST_OK};
        if (flushing) begin
            if (!i_buf_full) begin
                o_push       = 1'b1;
                n_window     = full[WIN_W-1:0];
                n_flush_left = r_flush_left - CNT_W'(1);
                o_result     = '{cell_bit: new_cell, last: (r_flush_left == CNT_W'(1)),
                                 status: ST_OK};
                if (r_flush_left == CNT_W'(1)) begin
                    n_bg = bg_update;
                end
            end
        end else if (accept) begin
            o_push = 1'b1;
            if (!rule_ok) begin
                o_result = '{cell_bit: 1'b0, last: 1'b0, status: ST_BAD_RULE};
            end else if (i_mode) begin
                n_bg     = 1'b0;
                n_in_gen = 1'b0;
                n_odd    = 1'b0;
                n_window = '0;
                o_result = '{cell_bit: 1'b1, last: 1'b1, status: ST_OK};
            end else begin
                n_window = full[WIN_W-1:0];
                n_odd    = odd_new;
                n_in_gen = !i_last;
                if (!i_last) begin
                    o_result = '{cell_bit: new_cell, last: 1'b0, status: ST_OK};
                end else if (!odd_new) begin
                    o_result = '{cell_bit: new_cell, last: 1'b1, status: ST_EVEN_LEN};
                end else if (r_pc == 3'd1) begin
                    o_result = '{cell_bit: new_cell, last: 1'b1, status: ST_OK};
                    n_bg     = bg_update;
                end else begin
                    o_result     = '{cell_bit: new_cell, last: 1'b0, status: ST_OK};
                    n_flush_left = CNT_W'(r_pc - 3'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= PCOUNT_W'(1);
            r_rule       <= '0;
            r_window     <= '0;
            r_bg         <= 1'b0;
            r_odd        <= 1'b0;
            r_in_gen     <= 1'b0;
            r_flush_left <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PARENT_COUNT: r_pc   <= i_cfg_data[PCOUNT_W-1:0];
                    CFG_RULE_WORD:    r_rule <= i_cfg_data[RULE_W-1:0];
                    default:          r_rule <= r_rule;
                endcase
            end
            r_window     <= n_window;
            r_bg         <= n_bg;
            r_odd        <= n_odd;
            r_in_gen     <= n_in_gen;
            r_flush_left <= n_flush_left;
        end
    end

endmodule : cang_core
`default_nettype wire

>>> hw/rtl/cang_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cang_out_buf
// Two-entry result buffer; its full flag depends on registers only.
// ----------------------------------------------------------------------------
module cang_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  cang_pkg::t_result       i_result,
    output logic                    o_full,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cang_pkg::t_result       o_result
);
    import cang_pkg::*;

    t_result     r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        pop;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule : cang_out_buf
`default_nettype wire

>>> hw/rtl/cellular_automaton_next_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cellular_automaton_next_gen
// Streams the next generation of a one-dimensional cellular automaton.
// ----------------------------------------------------------------------------
// Usage: program parent_count (index 0) and rule_word (index 1) through the
// cfg channel while the block is idle; cfg writes are always accepted.
// Each input beat carries one cell of the current generation (oldest first)
// in tdata bit 0, the generation's last cell flagged by tlast, and a seed
// request in tuser. Each output beat carries one next-generation cell in
// tdata bit 0, the end of the next generation on tlast and a status in tuser.
// s_axis_tready is low while the buffer is full or a flush runs; else a new
// beat is taken every cycle. The last cell of an odd-length generation adds
// parent_count-1 flush beats, one per cycle unless the buffer is full. A
// two-entry output buffer decouples the sides: while the receiver stalls the
// block still accepts until the buffer is full, and no result is ever
// dropped. Reset (synchronous, active low) empties the buffer, clears the
// window and background bit and sets parent_count to 1, rule_word to 0. An
// invalid rule gives one status beat per input beat.
// ----------------------------------------------------------------------------
module cellular_automaton_next_gen #(
    parameter int MAX_NEIGHBOURS = cang_pkg::MAX_NEIGHBOURS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write channel.
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cang_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cang_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input stream.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [0] cell_in
    input  wire logic                            s_axis_tlast,  // final_cell
    input  wire logic                            s_axis_tuser,  // [0] mode
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // [0] cell_out
    output logic                                 m_axis_tlast,  // end_of_run
    output logic [1:0]                           m_axis_tuser   // [1:0] status
);
    import cang_pkg::*;

    logic    buf_full;
    logic    push;
    t_result core_result;
    t_result out_result;

    assign o_cfg_ready = 1'b1;

    cang_core #(
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_mode      (s_axis_tuser),
        .i_cell      (s_axis_tdata[0]),
        .i_last      (s_axis_tlast),
        .i_buf_full  (buf_full),
        .o_in_ready  (s_axis_tready),
        .o_push      (push),
        .o_result    (core_result)
    );

    cang_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (core_result),
        .o_full   (buf_full),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {7'd0, out_result.cell_bit};
    assign m_axis_tlast = out_result.last;
    assign m_axis_tuser = out_result.status;

endmodule : cellular_automaton_next_gen
`default_nettype wire

>>> tb/cang_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cang_checker
// Scoreboard for the cellular automaton next-generation block. It follows the
// configuration writes, predicts the output beats of every accepted input beat
// and compares each accepted output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module cang_checker #(
    parameter int MAX_NEIGHBOURS = cang_pkg::MAX_NEIGHBOURS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [cang_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cang_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    input  wire logic [7:0]                      i_s_tdata,   // [0] cell_in
    input  wire logic                            i_s_tlast,   // final_cell
    input  wire logic                            i_s_tuser,   // [0] mode
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic [7:0]                      i_m_tdata,   // [0] cell_out
    input  wire logic                            i_m_tlast,   // end_of_run
    input  wire logic [1:0]                      i_m_tuser,   // [1:0] status
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import cang_pkg::*;

    localparam int WIN_W = MAX_NEIGHBOURS - 1;

    typedef struct packed {
        logic    value;
        logic    run_end;
        t_status status;
    } t_next_cell;

    t_next_cell               next_gen_q[$];
    int                       fails = 0;

    logic [PCOUNT_W-1:0]      pcount;
    logic [RULE_W-1:0]        rule;
    logic [WIN_W-1:0]         window;
    logic                     background;
    logic                     odd_len;
    logic                     in_gen;

    function automatic logic rule_fits();
        int entries;
        if (pcount == 0 || pcount > MAX_NEIGHBOURS) return 1'b0;
        entries = 1 << pcount;
        if (entries >= RULE_W) return 1'b1;
        return (rule >> entries) == '0;
    endfunction

    function automatic logic rule_at(int k);
        if (k >= RULE_W) return 1'b0;
        return rule[k];
    endfunction

    // Shifts one cell into the window and looks up the new cell.
    function automatic logic shift_window(logic cell_v);
        logic [WIN_W:0] full;
        full   = {window, cell_v};
        window = full[WIN_W-1:0];
        return rule_at(int'(full) & ((1 << pcount) - 1));
    endfunction

    function automatic void predict_next_cells(logic seed, logic cell_v, logic final_v);
        logic v;
        if (!rule_fits()) begin
            next_gen_q.push_back(t_next_cell'{1'b0, 1'b0, ST_BAD_RULE});
            return;
        end
        if (seed) begin
            background = 1'b0;
            in_gen     = 1'b0;
            odd_len    = 1'b0;
            window     = '0;
            next_gen_q.push_back(t_next_cell'{1'b1, 1'b1, ST_OK});
            return;
        end
        // A new generation starts from a window full of background cells.
        if (!in_gen) begin
            window  = background ? '1 : '0;
            odd_len = 1'b0;
            in_gen  = 1'b1;
        end
        odd_len = ~odd_len;
        v = shift_window(cell_v);
        if (!final_v) begin
            next_gen_q.push_back(t_next_cell'{v, 1'b0, ST_OK});
            return;
        end
        in_gen = 1'b0;
        if (!odd_len) begin
            next_gen_q.push_back(t_next_cell'{v, 1'b1, ST_EVEN_LEN});
            return;
        end
        next_gen_q.push_back(t_next_cell'{v, pcount == 1, ST_OK});
        for (int i = 1; i < pcount; i++) begin
            v = shift_window(background);
            next_gen_q.push_back(t_next_cell'{v, i + 1 == pcount, ST_OK});
        end
        background = background ? rule_at((1 << pcount) - 1) : rule_at(0);
    endfunction

    always @(posedge i_clk) begin
        t_next_cell want;
        t_next_cell got;
        if (!i_rst_n) begin
            pcount     = 1;
            rule       = '0;
            window     = '0;
            background = 1'b0;
            odd_len    = 1'b0;
            in_gen     = 1'b0;
            next_gen_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PARENT_COUNT)
                    pcount = i_cfg_data[PCOUNT_W-1:0];
                else if (i_cfg_index == CFG_RULE_WORD)
                    rule = i_cfg_data[RULE_W-1:0];
            end
            if (i_s_tvalid && i_s_tready)
                predict_next_cells(i_s_tuser, i_s_tdata[0], i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                got = t_next_cell'{i_m_tdata[0], i_m_tlast, t_status'(i_m_tuser)};
                if (next_gen_q.size() == 0) begin
                    $error({"output beat with nothing expected: ",
                            "cell_out=%0d end_of_run=%0d status=%0d"},
                           got.value, got.run_end, got.status);
                    fails++;
                end else begin
                    want = next_gen_q.pop_front();
                    if (got.value !== want.value) begin
                        $error("cell_out: expected %0d, got %0d", want.value, got.value);
                        fails++;
                    end
                    if (got.run_end !== want.run_end) begin
                        $error("end_of_run: expected %0d, got %0d", want.run_end, got.run_end);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= next_gen_q.size();
        o_fail_count <= fails;
    end

endmodule : cang_checker

>>> tb/tb_cellular_automaton_next_gen.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cellular_automaton_next_gen
// Drives cell, seed and configuration beats into the next-generation block
// while a separate checker predicts and compares every output beat. A short
// directed part hits the corner cases, then random generations run through
// many rule settings, in most of them with both stream sides stalling at random.
// ----------------------------------------------------------------------------
module tb_cellular_automaton_next_gen;
    import cang_pkg::*;

    // Input beat kinds carried on s_axis_tuser.
    localparam logic MODE_CELL = 1'b0;
    localparam logic MODE_SEED = 1'b1;

    // Far beyond the slowest legal run (about 330 beats, up to five output
    // beats each, every one behind a long receiver stall).
    localparam int CYCLE_LIMIT = 400_000;
    // Cycles allowed after the last expected beat before a register write
    // and before the verdict.
    localparam int SETTLE_CYCLES = 8;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PARENT_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  s_tuser   = MODE_CELL;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic [1:0]            m_tuser;

    int fail_count;
    int pending;
    int cycles       = 0;
    int snd_idle_pct = 34;
    int rcv_idle_pct = 57;

    cellular_automaton_next_gen uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .m_axis_tuser  (m_tuser)
    );

    cang_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver decides afresh every cycle whether it takes a beat, which
    // gives stalls of every length and on every phase of a flush.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Presents one input beat, optionally after a random gap, and returns at
    // the edge where it was accepted. tvalid stays high on return so that a
    // following beat can go out back to back.
    task automatic send_beat(input logic mode, input logic cell_v, input logic final_v);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, cell_v};
        s_tlast  <= final_v;
        s_tuser  <= mode;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Stops sending and waits until every predicted beat has come out, then
    // gives the block a few more cycles so stray beats would still be seen.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drains the outputs, then writes both registers back to back; cfg_valid
    // stays high in between so it is never lowered and raised within one time step.
    task automatic program_rule(input logic [PCOUNT_W-1:0] pc, input logic [RULE_W-1:0] rw);
        drain_outputs();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PARENT_COUNT;
        cfg_data  <= CFG_DATA_W'(pc);
        do @(posedge i_clk); while (!cfg_ready);
        cfg_index <= CFG_RULE_WORD;
        cfg_data  <= rw;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Bits of the rule word that a neighbourhood of pc cells can address.
    function automatic logic [RULE_W-1:0] usable_rule_bits(input int pc);
        if ((1 << pc) >= RULE_W) return '1;
        return (RULE_W'(1) << (1 << pc)) - 1;
    endfunction

    initial begin
        int                  pc;
        int                  left;
        int                  gen_len;
        int                  pick;
        logic [RULE_W-1:0]   mask;
        logic [RULE_W-1:0]   rw;
        bit                  paused;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- Directed part ------------------------------------------------
        // Reset configuration: one-cell neighbourhood, all-zero rule.
        send_beat(MODE_CELL, 1'b1, 1'b0);
        send_beat(MODE_CELL, 1'b1, 1'b1);

        // Identity rule with a single parent: odd generation ends on its own
        // cell, no flush.
        program_rule(3'd1, 32'h0000_0002);
        send_beat(MODE_CELL, 1'b1, 1'b0);
        send_beat(MODE_CELL, 1'b0, 1'b0);
        send_beat(MODE_CELL, 1'b1, 1'b1);

        // Three parents, rule 110. The seed carries cell and last bits that
        // must be ignored. Then an odd generation with a two-beat flush and
        // an even one that is only flagged.
        program_rule(3'd3, 32'h0000_006E);
        send_beat(MODE_SEED, 1'b1, 1'b1);
        send_beat(MODE_CELL, 1'b0, 1'b0);
        send_beat(MODE_CELL, 1'b1, 1'b0);
        send_beat(MODE_CELL, 1'b1, 1'b1);
        send_beat(MODE_CELL, 1'b1, 1'b0);
        send_beat(MODE_CELL, 1'b0, 1'b1);

        // Largest neighbourhood, all-ones rule: the background turns to one,
        // so the next generation starts from a window of ones.
        program_rule(3'd5, 32'hFFFF_FFFF);
        send_beat(MODE_CELL, 1'b0, 1'b1);
        send_beat(MODE_CELL, 1'b0, 1'b1);
        // Top rule bit clear: a background of one falls back to zero.
        program_rule(3'd5, 32'h7FFF_FFFF);
        send_beat(MODE_CELL, 1'b1, 1'b1);

        // Rule word wider than the table of two parents: every beat, seed
        // included, reports a bad rule and leaves the state alone.
        program_rule(3'd2, 32'h0000_0010);
        send_beat(MODE_CELL, 1'b1, 1'b1);
        send_beat(MODE_SEED, 1'b0, 1'b0);

        // Parent counts of zero and beyond the limit are bad rules as well.
        program_rule(3'd0, 32'h0000_0000);
        send_beat(MODE_CELL, 1'b0, 1'b1);
        program_rule(3'd7, 32'hFFFF_FFFF);
        send_beat(MODE_CELL, 1'b1, 1'b0);

        // ---- Random part --------------------------------------------------
        // Twelve settings of about 25 beats each. Most beats form complete
        // generations; a few are seeds or stray cells that break a sequence.
        paused = 1'b0;
        for (int phase = 0; phase < 12; phase++) begin
            if (phase < 4) begin
                snd_idle_pct = 34;
                rcv_idle_pct = 57;
            end else if (phase < 8) begin
                snd_idle_pct = 57;
                rcv_idle_pct = 34;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            pc   = (phase % 5) + 1;
            mask = usable_rule_bits(pc);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                rw = mask;
            else if (pick == 1)
                rw = '0;
            else if (pick == 2 && pc < 5)
                rw = $urandom() | (RULE_W'(1) << (1 << pc));   // bad rule
            else
                rw = $urandom() & mask;
            program_rule(PCOUNT_W'(pc), rw);

            left = 25;
            while (left > 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    send_beat(MODE_SEED, 1'($urandom()), 1'($urandom()));
                    left--;
                end else if (pick < 14) begin
                    send_beat(MODE_CELL, 1'($urandom()), 1'($urandom()));
                    left--;
                end else begin
                    gen_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                          : $urandom_range(1, 6);
                    for (int k = 0; k < gen_len; k++)
                        send_beat(MODE_CELL, 1'($urandom()), k == gen_len - 1);
                    left -= gen_len;
                end
                // Once, hold the sender back mid-setting until the output
                // side has caught up completely.
                if (phase == 5 && !paused && left < 12) begin
                    drain_outputs();
                    paused = 1'b1;
                end
            end
        end

        drain_outputs();
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule : tb_cellular_automaton_next_gen

>>> files.f
hw/rtl/cang_pkg.sv
hw/rtl/cang_core.sv
hw/rtl/cang_out_buf.sv
hw/rtl/cellular_automaton_next_gen.sv
tb/cang_checker.sv
tb/tb_cellular_automaton_next_gen.sv
